/* design/differential_dispersion_evaluator_macros.svh */
// Assertion macros used by the checker file
`ifndef DIFFERENTIAL_DISPERSION_EVALUATOR_MACROS_SVH
`define DIFFERENTIAL_DISPERSION_EVALUATOR_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define DDE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define DDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/dde_pkg.sv */
// Package: widths, command codes, controller states and control structs
`timescale 1ns / 1ps
package dde_pkg;
   localparam int MAX_NODES = 256;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int DIST_W    = 16;
   localparam int SUM_W     = 24;
   localparam int CNT_W     = NODE_W + 1;
   localparam int ADDR_W    = 2 * NODE_W;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_EVAL   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_FWD,
      ST_WR_REV,
      ST_SCAN,
      ST_FLUSH,
      ST_OWN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic wr_fwd;
      logic wr_rev;
      logic scan;
      logic own;
      logic resp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic is_write;
      logic scan_last;
      logic pipe_empty;
      logic out_busy;
   } dp_stat_type;
endpackage

/* design/dde_if.sv */
// Valid/ready channel interfaces for request and response words
`timescale 1ns / 1ps
interface dde_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  cmd;
   logic [dde_pkg::NODE_W-1:0]  node;
   logic [dde_pkg::NODE_W-1:0]  other_node;
   logic [dde_pkg::DIST_W-1:0]  distance;
   logic                        commit;
   modport source (output valid, cmd, node, other_node, distance, commit, input ready);
   modport sink   (input valid, cmd, node, other_node, distance, commit, output ready);
endinterface

interface dde_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dde_pkg::SUM_W-1:0]   dispersion;
   logic [dde_pkg::CNT_W-1:0]   member_count;
   logic                        status;
   modport source (output valid, dispersion, member_count, status, input ready);
   modport sink   (input valid, dispersion, member_count, status, output ready);
endinterface

/* design/differential_dispersion_evaluator.sv */
// Differential dispersion evaluator: top level
// Request channel req_if carries one command word: write a symmetric
// distance, insert a node, remove a node, or evaluate. Insert and remove
// apply to the held set when commit is high, otherwise they are a trial.
// Response channel rsp_if returns one word per command: the dispersion
// (largest minus smallest member sum), the member count and a status bit.
// Every command walks all 256 nodes once through a three stage scan of the
// distance and sum memories, after a distance write has stored both entries.
// A new request is taken only once the previous command has finished.
// A finished word waits in the output register; while it is stalled the
// block takes the next request and holds its own word until the register
// frees.
// Reset clears membership, member sums and the count at once; the distance
// matrix is not cleared and reads of unwritten entries are undefined.
`timescale 1ns / 1ps
module differential_dispersion_evaluator (
   input  logic       clock,
   input  logic       reset,
   dde_req_if.sink    req_if,
   dde_rsp_if.source  rsp_if
);
   dde_pkg::dp_cmd_type  cmd;
   dde_pkg::dp_stat_type stat;

   dde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dde_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .stat   (stat),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );
endmodule

/* design/dde_ctrl.sv */
// Command sequencer for the evaluator
`timescale 1ns / 1ps
module dde_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dde_pkg::dp_stat_type stat,
   output dde_pkg::dp_cmd_type  cmd
);
   dde_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dde_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dde_pkg::ST_IDLE: begin
            if (req_valid) state_in = dde_pkg::ST_WR_FWD;
         end
         dde_pkg::ST_WR_FWD: begin
            state_in = stat.is_write ? dde_pkg::ST_WR_REV : dde_pkg::ST_SCAN;
         end
         dde_pkg::ST_WR_REV: state_in = dde_pkg::ST_SCAN;
         dde_pkg::ST_SCAN: begin
            if (stat.scan_last) state_in = dde_pkg::ST_FLUSH;
         end
         dde_pkg::ST_FLUSH: begin
            if (stat.pipe_empty) state_in = dde_pkg::ST_OWN;
         end
         dde_pkg::ST_OWN: state_in = dde_pkg::ST_RESP;
         dde_pkg::ST_RESP: begin
            if (!stat.out_busy) state_in = dde_pkg::ST_IDLE;
         end
         default: state_in = dde_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         dde_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         dde_pkg::ST_WR_FWD: cmd.wr_fwd = stat.is_write;
         dde_pkg::ST_WR_REV: cmd.wr_rev = 1'b1;
         dde_pkg::ST_SCAN:   cmd.scan   = 1'b1;
         dde_pkg::ST_FLUSH:  cmd        = '0;
         dde_pkg::ST_OWN:    cmd.own    = 1'b1;
         dde_pkg::ST_RESP:   cmd.resp_load = !stat.out_busy;
         default:            cmd        = '0;
      endcase
   end
endmodule

/* design/dde_datapath.sv */
// Distance matrix, member state, scan pipeline and response register
`timescale 1ns / 1ps
module dde_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  dde_pkg::dp_cmd_type  cmd,
   output dde_pkg::dp_stat_type stat,
   dde_req_if.sink              req_if,
   dde_rsp_if.source            rsp_if
);
   localparam int NW = dde_pkg::NODE_W;
   localparam int SW = dde_pkg::SUM_W;
   localparam int CW = dde_pkg::CNT_W;

   logic [dde_pkg::DIST_W-1:0] dist_mem [dde_pkg::MAX_NODES*dde_pkg::MAX_NODES];
   logic [SW-1:0]              sum_mem  [dde_pkg::MAX_NODES];

   logic [1:0]                 op_ff;
   logic [NW-1:0]              node_ff, other_ff;
   logic [dde_pkg::DIST_W-1:0] dist_ff;
   logic                       commit_ff, mod_ff, ins_ff, status_ff;
   logic [dde_pkg::MAX_NODES-1:0] bits_ff, sval_ff;
   logic [CW-1:0]              count_ff;

   logic [NW-1:0]              idx_ff;
   logic                       p1_valid_ff, p1_sval_ff;
   logic [NW-1:0]              p1_idx_ff;
   logic [dde_pkg::DIST_W-1:0] rd_dist_ff;
   logic [SW-1:0]              rd_sum_ff;
   logic                       p2_valid_ff, p2_member_ff;
   logic [NW-1:0]              p2_idx_ff;
   logic [SW-1:0]              p2_sum_ff, own_ff, hi_ff, lo_ff;
   logic                       any_ff;

   logic                       rsp_valid_ff, rsp_status_ff;
   logic [SW-1:0]              rsp_disp_ff;
   logic [CW-1:0]              rsp_count_ff, res_count_ff, new_count;

   logic                       in_range, req_member, req_mod, p1_member;
   logic [SW-1:0]              p1_sum, p1_dist, p1_new, own_new;
   logic [SW:0]                add_full, own_full;
   logic                       upd_hi, upd_lo;
   logic [SW-1:0]              cand;
   logic                       cand_valid;

   // request decode at capture
   assign in_range   = (CW'(req_if.node) < CW'(dde_pkg::MAX_NODES)) &&
                       (CW'(req_if.other_node) < CW'(dde_pkg::MAX_NODES));
   assign req_member = bits_ff[req_if.node];
   assign req_mod    = in_range &&
                       (((req_if.cmd == dde_pkg::CMD_INSERT) && !req_member) ||
                        ((req_if.cmd == dde_pkg::CMD_REMOVE) && req_member));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_if.cmd;
         node_ff   <= req_if.node;
         other_ff  <= req_if.other_node;
         dist_ff   <= req_if.distance;
         commit_ff <= req_if.commit;
         mod_ff    <= req_mod;
         ins_ff    <= req_if.cmd == dde_pkg::CMD_INSERT;
         unique case (req_if.cmd)
            dde_pkg::CMD_WRITE: status_ff <= !in_range;
            dde_pkg::CMD_EVAL:  status_ff <= 1'b0;
            default:            status_ff <= !req_mod;
         endcase
      end
   end

   // distance matrix: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_fwd) dist_mem[{node_ff, other_ff}] <= dist_ff;
      if (cmd.wr_rev) dist_mem[{other_ff, node_ff}] <= dist_ff;
      rd_dist_ff <= dist_mem[{idx_ff, node_ff}];
   end

   // member sums; entries without a valid bit read as zero
   always_ff @(posedge clock) begin
      rd_sum_ff <= sum_mem[idx_ff];
      if (p2_valid_ff && p2_member_ff && mod_ff && commit_ff)
         sum_mem[p2_idx_ff] <= p2_sum_ff;
      if (cmd.own && mod_ff && commit_ff && ins_ff)
         sum_mem[node_ff] <= own_ff;
   end

   // scan stage 1: sum update and own accumulation
   assign p1_member = bits_ff[p1_idx_ff] && !(mod_ff && (p1_idx_ff == node_ff));
   assign p1_sum    = p1_sval_ff ? rd_sum_ff : '0;
   assign p1_dist   = SW'(rd_dist_ff);
   assign add_full  = {1'b0, p1_sum} + {1'b0, p1_dist};
   assign own_full  = {1'b0, own_ff} + {1'b0, p1_dist};
   assign own_new   = own_full[SW] ? dde_pkg::SUM_MAX : own_full[SW-1:0];

   always_comb begin
      if (!mod_ff) begin
         p1_new = p1_sum;
      end else if (ins_ff) begin
         p1_new = add_full[SW] ? dde_pkg::SUM_MAX : add_full[SW-1:0];
      end else begin
         p1_new = (p1_sum > p1_dist) ? (p1_sum - p1_dist) : '0;
      end
   end

   // stage 2 candidate, or the new node's own sum at the end of an insert
   always_comb begin
      if (cmd.own) begin
         cand       = own_ff;
         cand_valid = mod_ff && ins_ff;
      end else begin
         cand       = p2_sum_ff;
         cand_valid = p2_valid_ff && p2_member_ff;
      end
   end
   assign upd_hi = cand_valid && (!any_ff || (cand > hi_ff));
   assign upd_lo = cand_valid && (!any_ff || (cand < lo_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         idx_ff      <= '0;
         any_ff      <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.scan;
         p2_valid_ff <= p1_valid_ff;
         if (cmd.scan) idx_ff <= idx_ff + 1'b1;
         if (cmd.capture) any_ff <= 1'b0;
         else if (cand_valid) any_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff    <= idx_ff;
      p1_sval_ff   <= sval_ff[idx_ff];
      p2_idx_ff    <= p1_idx_ff;
      p2_member_ff <= p1_member;
      p2_sum_ff    <= p1_new;
      if (cmd.capture) begin
         own_ff <= '0;
      end else if (p1_valid_ff && p1_member) begin
         own_ff <= own_new;
      end
      if (upd_hi) hi_ff <= cand;
      if (upd_lo) lo_ff <= cand;
   end

   // committed membership
   assign new_count = !mod_ff ? count_ff : (ins_ff ? count_ff + 1'b1 : count_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         sval_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (p2_valid_ff && p2_member_ff && mod_ff && commit_ff)
            sval_ff[p2_idx_ff] <= 1'b1;
         if (cmd.own && mod_ff && commit_ff) begin
            bits_ff[node_ff] <= ins_ff;
            sval_ff[node_ff] <= ins_ff;
            count_ff         <= new_count;
         end
      end
   end

   // response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.resp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.own) res_count_ff <= new_count;
      if (cmd.resp_load) begin
         rsp_disp_ff   <= any_ff ? hi_ff - lo_ff : '0;
         rsp_count_ff  <= res_count_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.dispersion   = rsp_disp_ff;
   assign rsp_if.member_count = rsp_count_ff;
   assign rsp_if.status       = rsp_status_ff;

   assign stat.is_write   = op_ff == dde_pkg::CMD_WRITE && !status_ff;
   assign stat.scan_last  = idx_ff == NW'(dde_pkg::MAX_NODES - 1);
   assign stat.pipe_empty = !p1_valid_ff && !p2_valid_ff;
   assign stat.out_busy   = rsp_valid_ff && !rsp_if.ready;
endmodule

/* design/dde_checker.sv */
// Port checker for the evaluator, bound to the top level
`timescale 1ns / 1ps
`include "differential_dispersion_evaluator_macros.svh"
module dde_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [dde_pkg::CNT_W-1:0]  rsp_member_count,
   input logic [dde_pkg::SUM_W-1:0]  rsp_dispersion
);
   `DDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_dispersion))
   `DDE_ASSERT_IMPLY(a_count_max, clock, reset, rsp_valid, rsp_member_count <= dde_pkg::CNT_W'(dde_pkg::MAX_NODES))
   `DDE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `DDE_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid))
endmodule

bind differential_dispersion_evaluator dde_checker u_dde_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_member_count (rsp_if.member_count),
   .rsp_dispersion   (rsp_if.dispersion)
);
